[rtl/core/tpcs_pkg.sv]
// ----------------------------------------------------------------------------
// Two-process schedule stepper package
// Shared types for the process states, the scheduling policy and the
// configuration register set.
// ----------------------------------------------------------------------------
package tpcs_pkg;

	typedef enum logic [1:0] {
		ST_READY = 2'd0,
		ST_RUN   = 2'd1,
		ST_WAIT  = 2'd2,
		ST_DONE  = 2'd3
	} proc_state_t;

	typedef enum logic [1:0] {
		POL_FCFS = 2'd0,
		POL_SJF  = 2'd1,
		POL_PSJF = 2'd2,
		POL_RR   = 2'd3
	} policy_t;

	typedef enum logic [2:0] {
		REG_POLICY       = 3'd0,
		REG_FIRST_CPU_A  = 3'd1,
		REG_IO_A         = 3'd2,
		REG_SECOND_CPU_A = 3'd3,
		REG_FIRST_CPU_B  = 3'd4,
		REG_IO_B         = 3'd5,
		REG_SECOND_CPU_B = 3'd6,
		REG_QUANTUM      = 3'd7
	} reg_index_t;

	typedef struct packed {
		policy_t    policy;
		logic [7:0] first_cpu_a;
		logic [7:0] io_a;
		logic [7:0] second_cpu_a;
		logic [7:0] first_cpu_b;
		logic [7:0] io_b;
		logic [7:0] second_cpu_b;
		logic [7:0] quantum;
	} cfg_t;

endpackage

[rtl/core/tpcs_step.sv]
// ----------------------------------------------------------------------------
// Schedule tick logic
// Combinational next-state logic for one tick: restart, burst completion, preemption,
// quantum expiry, I/O completion, dispatch and counter updates.
// ----------------------------------------------------------------------------
module tpcs_step #(
	parameter int COUNT_BITS = 8
) (
	input  tpcs_pkg::cfg_t          cfg,
	input  logic                    restart,
	input  tpcs_pkg::proc_state_t   cur_state_a,
	input  tpcs_pkg::proc_state_t   cur_state_b,
	input  logic [COUNT_BITS-1:0]   cur_cpu_a,
	input  logic [COUNT_BITS-1:0]   cur_cpu_b,
	input  logic [COUNT_BITS-1:0]   cur_io_a,
	input  logic [COUNT_BITS-1:0]   cur_io_b,
	input  logic signed [8:0]       cur_slice,
	output tpcs_pkg::proc_state_t   nxt_state_a,
	output tpcs_pkg::proc_state_t   nxt_state_b,
	output logic [COUNT_BITS-1:0]   nxt_cpu_a,
	output logic [COUNT_BITS-1:0]   nxt_cpu_b,
	output logic [COUNT_BITS-1:0]   nxt_io_a,
	output logic [COUNT_BITS-1:0]   nxt_io_b,
	output logic signed [8:0]       nxt_slice,
	output tpcs_pkg::proc_state_t   res_state_a,
	output tpcs_pkg::proc_state_t   res_state_b,
	output logic                    res_all_done
);

	function automatic logic [COUNT_BITS-1:0] fit(input logic [7:0] v);
		logic [15:0] w;
		w = {8'd0, v};
		return w[COUNT_BITS-1:0];
	endfunction

	function automatic logic [COUNT_BITS-1:0] dec_sat(input logic [COUNT_BITS-1:0] v);
		return (v == '0) ? '0 : v - COUNT_BITS'(1);
	endfunction

	tpcs_pkg::proc_state_t sa;
	tpcs_pkg::proc_state_t sb;
	logic [COUNT_BITS-1:0] ca;
	logic [COUNT_BITS-1:0] cb;
	logic [COUNT_BITS-1:0] ia;
	logic [COUNT_BITS-1:0] ib;
	logic signed [8:0]     sl;
	logic                  shortest;
	logic                  done;

	always_comb begin
		sa = cur_state_a;
		sb = cur_state_b;
		ca = cur_cpu_a;
		cb = cur_cpu_b;
		ia = cur_io_a;
		ib = cur_io_b;
		sl = cur_slice;
		shortest = (cfg.policy == tpcs_pkg::POL_SJF) || (cfg.policy == tpcs_pkg::POL_PSJF);

		if (restart) begin
			sa = tpcs_pkg::ST_READY;
			sb = tpcs_pkg::ST_READY;
			ca = fit(cfg.first_cpu_a);
			cb = fit(cfg.first_cpu_b);
			ia = fit(cfg.io_a);
			ib = fit(cfg.io_b);
			sl = '0;
		end

		if (!(sa == tpcs_pkg::ST_DONE && sb == tpcs_pkg::ST_DONE)) begin
			if (sa == tpcs_pkg::ST_RUN && ca == '0) begin
				sa = (ia == '0) ? tpcs_pkg::ST_DONE : tpcs_pkg::ST_WAIT;
			end else if (sb == tpcs_pkg::ST_RUN && cb == '0) begin
				sb = (ib == '0) ? tpcs_pkg::ST_DONE : tpcs_pkg::ST_WAIT;
			end else if (cfg.policy == tpcs_pkg::POL_PSJF) begin
				if (sa == tpcs_pkg::ST_RUN && cb < ca && cb != '0) begin
					sa = tpcs_pkg::ST_READY;
					sb = tpcs_pkg::ST_RUN;
				end else if (sb == tpcs_pkg::ST_RUN && ca < cb && ca != '0) begin
					sa = tpcs_pkg::ST_RUN;
					sb = tpcs_pkg::ST_READY;
				end
			end

			if (cfg.policy == tpcs_pkg::POL_RR) begin
				if (sa == tpcs_pkg::ST_RUN && sl == 9'sd0 && cb != '0) begin
					sa = tpcs_pkg::ST_READY;
					sb = tpcs_pkg::ST_RUN;
					sl = $signed({1'b0, cfg.quantum});
				end
				if (sb == tpcs_pkg::ST_RUN && sl == 9'sd0 && ca != '0) begin
					sa = tpcs_pkg::ST_RUN;
					sb = tpcs_pkg::ST_READY;
					sl = $signed({1'b0, cfg.quantum});
				end
			end

			if (sa == tpcs_pkg::ST_WAIT && ia == '0) begin
				sa = tpcs_pkg::ST_READY;
				if (cfg.policy != tpcs_pkg::POL_PSJF || ca == '0) begin
					ca = fit(cfg.second_cpu_a);
				end
			end
			if (sb == tpcs_pkg::ST_WAIT && ib == '0) begin
				sb = tpcs_pkg::ST_READY;
				if (cfg.policy != tpcs_pkg::POL_PSJF || cb == '0) begin
					cb = fit(cfg.second_cpu_b);
				end
			end

			if (sa == tpcs_pkg::ST_READY && sb == tpcs_pkg::ST_READY) begin
				if (shortest && ca > cb) begin
					sb = tpcs_pkg::ST_RUN;
				end else begin
					sa = tpcs_pkg::ST_RUN;
					if (cfg.policy == tpcs_pkg::POL_RR) begin
						sl = $signed({1'b0, cfg.quantum});
					end
				end
			end else if (sa == tpcs_pkg::ST_READY && sb != tpcs_pkg::ST_RUN) begin
				sa = tpcs_pkg::ST_RUN;
			end else if (sb == tpcs_pkg::ST_READY && sa != tpcs_pkg::ST_RUN) begin
				sb = tpcs_pkg::ST_RUN;
			end
		end

		done = (sa == tpcs_pkg::ST_DONE) && (sb == tpcs_pkg::ST_DONE);
		res_state_a  = sa;
		res_state_b  = sb;
		res_all_done = done;

		if (!done) begin
			if (cfg.policy == tpcs_pkg::POL_RR && sl != -9'sd1) begin
				sl = sl - 9'sd1;
			end
			if (sa == tpcs_pkg::ST_RUN) begin
				ca = dec_sat(ca);
			end
			if (sa == tpcs_pkg::ST_WAIT) begin
				ia = dec_sat(ia);
			end
			if (sb == tpcs_pkg::ST_RUN) begin
				cb = dec_sat(cb);
			end
			if (sb == tpcs_pkg::ST_WAIT) begin
				ib = dec_sat(ib);
			end
		end

		nxt_state_a = sa;
		nxt_state_b = sb;
		nxt_cpu_a   = ca;
		nxt_cpu_b   = cb;
		nxt_io_a    = ia;
		nxt_io_b    = ib;
		nxt_slice   = sl;
	end

endmodule

[rtl/core/two_process_cpu_schedule_stepper.sv]
// ----------------------------------------------------------------------------
// Two-process CPU schedule stepper
// Flow: the tick logic sits between one input register and the result
// register; a stalled result holds a request in the input register.
// Throughput: one request per cycle while the result register is free or
// m_axis_tready is high; the schedule state updates as a request moves into
// the result register. Reset: asynchronous, active low; valid flags, config
// and schedule take reset values; restart_s1 and out_data_q are not reset.
// ----------------------------------------------------------------------------
module two_process_cpu_schedule_stepper #(
	parameter int COUNT_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [0] restart, [7:1] zero
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // [1:0] state_a, [3:2] state_b, [4] all_done
);

	tpcs_pkg::cfg_t        cfg_q;
	logic                  valid_s1;
	logic                  restart_s1;
	logic                  out_valid_q;
	logic [4:0]            out_data_q;
	logic                  advance;

	tpcs_pkg::proc_state_t state_a_q, state_b_q;
	logic [COUNT_BITS-1:0] cpu_a_q, cpu_b_q, io_a_q, io_b_q;
	logic signed [8:0]     slice_q;

	tpcs_pkg::proc_state_t nxt_state_a, nxt_state_b;
	logic [COUNT_BITS-1:0] nxt_cpu_a, nxt_cpu_b, nxt_io_a, nxt_io_b;
	logic signed [8:0]     nxt_slice;
	tpcs_pkg::proc_state_t res_state_a, res_state_b;
	logic                  res_all_done;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy       <= tpcs_pkg::POL_FCFS;
			cfg_q.first_cpu_a  <= 8'd1;
			cfg_q.io_a         <= 8'd1;
			cfg_q.second_cpu_a <= 8'd1;
			cfg_q.first_cpu_b  <= 8'd1;
			cfg_q.io_b         <= 8'd1;
			cfg_q.second_cpu_b <= 8'd1;
			cfg_q.quantum      <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tpcs_pkg::reg_index_t'(cfg_index))
				tpcs_pkg::REG_POLICY:
					cfg_q.policy <= tpcs_pkg::policy_t'(cfg_data[1:0]);
				tpcs_pkg::REG_FIRST_CPU_A:  cfg_q.first_cpu_a  <= cfg_data;
				tpcs_pkg::REG_IO_A:         cfg_q.io_a         <= cfg_data;
				tpcs_pkg::REG_SECOND_CPU_A: cfg_q.second_cpu_a <= cfg_data;
				tpcs_pkg::REG_FIRST_CPU_B:  cfg_q.first_cpu_b  <= cfg_data;
				tpcs_pkg::REG_IO_B:         cfg_q.io_b         <= cfg_data;
				tpcs_pkg::REG_SECOND_CPU_B: cfg_q.second_cpu_b <= cfg_data;
				tpcs_pkg::REG_QUANTUM:      cfg_q.quantum      <= cfg_data;
				default:                    cfg_q.quantum      <= cfg_q.quantum;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			restart_s1 <= s_axis_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			state_a_q   <= tpcs_pkg::ST_READY;
			state_b_q   <= tpcs_pkg::ST_READY;
			cpu_a_q     <= COUNT_BITS'(1);
			cpu_b_q     <= COUNT_BITS'(1);
			io_a_q      <= COUNT_BITS'(1);
			io_b_q      <= COUNT_BITS'(1);
			slice_q     <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				state_a_q   <= nxt_state_a;
				state_b_q   <= nxt_state_b;
				cpu_a_q     <= nxt_cpu_a;
				cpu_b_q     <= nxt_cpu_b;
				io_a_q      <= nxt_io_a;
				io_b_q      <= nxt_io_b;
				slice_q     <= nxt_slice;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {res_all_done, res_state_b, res_state_a};
		end
	end

	tpcs_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.cfg          (cfg_q),
		.restart      (restart_s1),
		.cur_state_a  (state_a_q),
		.cur_state_b  (state_b_q),
		.cur_cpu_a    (cpu_a_q),
		.cur_cpu_b    (cpu_b_q),
		.cur_io_a     (io_a_q),
		.cur_io_b     (io_b_q),
		.cur_slice    (slice_q),
		.nxt_state_a  (nxt_state_a),
		.nxt_state_b  (nxt_state_b),
		.nxt_cpu_a    (nxt_cpu_a),
		.nxt_cpu_b    (nxt_cpu_b),
		.nxt_io_a     (nxt_io_a),
		.nxt_io_b     (nxt_io_b),
		.nxt_slice    (nxt_slice),
		.res_state_a  (res_state_a),
		.res_state_b  (res_state_b),
		.res_all_done (res_all_done)
	);

endmodule
